// ===== hw/rtl/ssxpf_pkg.sv =====
// Shared types and constants of the sync-word packet framer.
package ssxpf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SLOT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hD3;
    localparam logic [LEN_W-1:0]  LENGTH_RESET      = 5'd7;

    localparam logic [SLOT_W-1:0] SLOT_SYNC_FIRST  = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_SYNC_SECOND = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_SEQ         = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_PAYLOAD     = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_CHECK       = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  payload_length;
    } cfg_t;

    typedef struct packed {
        logic              has_header;
        logic              has_check;
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] checksum;
    } burst_t;

endpackage

// ===== hw/rtl/ssxpf_if.sv =====
// Stream interfaces for the payload input and the line output of the framer.
interface ssxpf_payload_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;

    modport source (output valid, output payload_byte, input ready);
    modport sink (input valid, input payload_byte, output ready);
endinterface

interface ssxpf_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       packet_end;
    logic       run_end;

    modport source (output valid, output line_byte, output packet_end, output run_end,
                    input ready);
    modport sink (input valid, input line_byte, input packet_end, input run_end,
                  output ready);
endinterface

// ===== hw/rtl/ssxpf_frame.sv =====
// Input register and packet state; builds the group of line bytes for one payload byte.
module ssxpf_frame #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssxpf_pkg::cfg_t     cfg,
    ssxpf_payload_if.sink       payload,
    output logic                burst_valid,
    output ssxpf_pkg::burst_t   burst,
    input  logic                burst_take
);
    import ssxpf_pkg::*;

    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam int CW = (PW > LEN_W) ? PW : LEN_W;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] seq_reg;
    logic [BYTE_W-1:0] seq_next;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic [BYTE_W-1:0] xor_reg;
    logic [BYTE_W-1:0] xor_next;

    logic [CW-1:0]     len_ext;
    logic [CW-1:0]     eff_len;
    logic [CW-1:0]     count;
    logic              header;
    logic              closes;
    logic [BYTE_W-1:0] sum;

    assign payload.ready = !valid_reg || burst_take;
    assign burst_valid   = valid_reg;

    always_comb
    begin
        len_ext = CW'(cfg.payload_length);
        if (len_ext == '0)
        begin
            eff_len = CW'(1);
        end
        else if (len_ext > CW'(MAX_PAYLOAD))
        begin
            eff_len = CW'(MAX_PAYLOAD);
        end
        else
        begin
            eff_len = len_ext;
        end
        header = (pos_reg == '0);
        sum    = (header ? seq_reg : xor_reg) ^ byte_reg;
        count  = CW'(pos_reg) + CW'(1);
        closes = (count >= eff_len);

        burst.has_header  = header;
        burst.has_check   = closes;
        burst.sync_first  = cfg.sync_first;
        burst.sync_second = cfg.sync_second;
        burst.seq         = seq_reg;
        burst.payload     = byte_reg;
        burst.checksum    = sum;
    end

    always_comb
    begin
        valid_next = valid_reg;
        seq_next   = seq_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        if (burst_take)
        begin
            valid_next = 1'b0;
            if (closes)
            begin
                seq_next = seq_reg + 8'd1;
                pos_next = '0;
                xor_next = '0;
            end
            else
            begin
                pos_next = PW'(count);
                xor_next = sum;
            end
        end
        if (payload.valid && payload.ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seq_reg   <= '0;
            pos_reg   <= '0;
            xor_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            seq_reg   <= seq_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (payload.valid && payload.ready)
        begin
            byte_reg <= payload.payload_byte;
        end
    end

endmodule

// ===== hw/rtl/ssxpf_emit.sv =====
// Result register that sends the bytes of one group to the line, one per transfer.
module ssxpf_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                burst_valid,
    input  ssxpf_pkg::burst_t   burst,
    output logic                burst_take,
    ssxpf_line_if.source        line
);
    import ssxpf_pkg::*;

    burst_t            burst_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic [SLOT_W-1:0] last_slot;
    logic              last;

    assign last_slot  = burst_reg.has_check ? SLOT_CHECK : SLOT_PAYLOAD;
    assign last       = (idx_reg == last_slot);
    assign burst_take = burst_valid && (!busy_reg || (line.ready && last));

    assign line.valid      = busy_reg;
    assign line.packet_end = (idx_reg == SLOT_CHECK);
    assign line.run_end    = last;

    always_comb
    begin
        case (idx_reg)
            SLOT_SYNC_FIRST:  line.line_byte = burst_reg.sync_first;
            SLOT_SYNC_SECOND: line.line_byte = burst_reg.sync_second;
            SLOT_SEQ:         line.line_byte = burst_reg.seq;
            SLOT_PAYLOAD:     line.line_byte = burst_reg.payload;
            default:          line.line_byte = burst_reg.checksum;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (burst_take)
        begin
            busy_next = 1'b1;
            idx_next  = burst.has_header ? SLOT_SYNC_FIRST : SLOT_PAYLOAD;
        end
        else if (busy_reg && line.ready)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= SLOT_PAYLOAD;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_take)
        begin
            burst_reg <= burst;
        end
    end

endmodule

// ===== hw/rtl/sync_seq_xor_packet_framer.sv =====
// Top level of the sync-word packet framer with XOR checksum.
// A payload byte passes the input register and then the result register before its first line byte is valid.
// Throughput: one line byte per cycle while the line is ready; a payload byte gives one to five
// line bytes (two sync bytes and the sequence number at packet start, the checksum at its end).
// Reset: asynchronous, active low; clears sequence, position and checksum state and loads
// the configuration registers with their default values.
module sync_seq_xor_packet_framer #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ssxpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssxpf_pkg::CFG_DATA_W-1:0]  cfg_data,
    ssxpf_payload_if.sink                     payload,
    ssxpf_line_if.source                      line
);
    import ssxpf_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   burst_valid;
    burst_t burst;
    logic   burst_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:     cfg_next.sync_first     = cfg_data;
                REG_SYNC_SECOND:    cfg_next.sync_second    = cfg_data;
                REG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_data[LEN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first     <= SYNC_FIRST_RESET;
            cfg_reg.sync_second    <= SYNC_SECOND_RESET;
            cfg_reg.payload_length <= LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssxpf_frame #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .payload     (payload),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_take  (burst_take)
    );

    ssxpf_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_take  (burst_take),
        .line        (line)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the sync-word packet framer with XOR checksum.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ssxpf_pkg::*;

    localparam int MAX_PAYLOAD = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 200;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic [BYTE_W-1:0] line_byte;
        logic              packet_end;
        logic              run_end;
    } line_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssxpf_payload_if payload_ch ();
    ssxpf_line_if    line_ch ();

    sync_seq_xor_packet_framer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .payload(payload_ch),
        .line(line_ch)
    );

    cfg_t shadow_cfg = '{sync_first: SYNC_FIRST_RESET, sync_second: SYNC_SECOND_RESET,
                         payload_length: LENGTH_RESET};
    logic [BYTE_W-1:0] seq_num = '0;
    logic [BYTE_W-1:0] xor_acc = '0;
    int                fill_count = 0;

    logic [BYTE_W-1:0] payload_backlog[$];
    line_beat_t        owed_line[$];

    int fail_count = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pause_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void frame_payload(input logic [BYTE_W-1:0] data);
        int  limit;
        bit  closing;
        limit = shadow_cfg.payload_length;
        if (limit == 0)
            limit = 1;
        if (limit > MAX_PAYLOAD)
            limit = MAX_PAYLOAD;
        if (fill_count == 0)
        begin
            owed_line.push_back('{shadow_cfg.sync_first, 1'b0, 1'b0});
            owed_line.push_back('{shadow_cfg.sync_second, 1'b0, 1'b0});
            owed_line.push_back('{seq_num, 1'b0, 1'b0});
            xor_acc = seq_num;
        end
        closing = (fill_count + 1 >= limit);
        owed_line.push_back('{data, 1'b0, !closing});
        xor_acc = xor_acc ^ data;
        fill_count++;
        if (closing)
        begin
            owed_line.push_back('{xor_acc, 1'b1, 1'b1});
            seq_num = seq_num + 8'd1;
            fill_count = 0;
            xor_acc = '0;
        end
    endfunction

    function automatic void check_line_beat();
        line_beat_t want;
        if (owed_line.size() == 0)
        begin
            $error("unexpected line transfer: line_byte %0h", line_ch.line_byte);
            fail_count++;
        end
        else
        begin
            want = owed_line.pop_front();
            if (line_ch.line_byte !== want.line_byte)
            begin
                $error("line_byte: expected %0h, got %0h", want.line_byte, line_ch.line_byte);
                fail_count++;
            end
            if (line_ch.packet_end !== want.packet_end)
            begin
                $error("packet_end: expected %0b, got %0b", want.packet_end,
                       line_ch.packet_end);
                fail_count++;
            end
            if (line_ch.run_end !== want.run_end)
            begin
                $error("run_end: expected %0b, got %0b", want.run_end, line_ch.run_end);
                fail_count++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_ch.valid <= 1'b0;
            payload_ch.payload_byte <= '0;
            gap_left = 0;
        end
        else
        begin
            if (payload_ch.valid && payload_ch.ready)
                frame_payload(payload_ch.payload_byte);
            if (!payload_ch.valid || payload_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    payload_ch.valid <= 1'b0;
                end
                else if (payload_backlog.size() != 0)
                begin
                    payload_ch.valid <= 1'b1;
                    payload_ch.payload_byte <= payload_backlog.pop_front();
                    if (gaps_on && $urandom_range(0, 3) == 0)
                        gap_left = pause_length();
                end
                else
                    payload_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (line_ch.valid && line_ch.ready)
                check_line_beat();
            if (stall_left != 0)
            begin
                stall_left--;
                line_ch.ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = pause_length() - 1;
                line_ch.ready <= 1'b0;
            end
            else
                line_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sync_seq_xor_packet_framer: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_SYNC_FIRST:     shadow_cfg.sync_first = value;
            REG_SYNC_SECOND:    shadow_cfg.sync_second = value;
            REG_PAYLOAD_LENGTH: shadow_cfg.payload_length = value[LEN_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        while (payload_backlog.size() != 0 || payload_ch.valid || owed_line.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count) payload_backlog.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_sync();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        if (r < 4)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 8'd1;
        if (r < 45)
            return 8'd0;
        if (r < 70)
            return 8'($urandom_range(2, 8));
        if (r < 78)
            return 8'd16;
        if (r < 88)
            return {3'($urandom_range(0, 7)), 5'($urandom_range(17, 31))};
        return 8'($urandom_range(9, 15));
    endfunction

    initial
    begin
        int phase;
        int phase_items;
        int random_sent;
        payload_ch.valid = 1'b0;
        payload_ch.payload_byte = '0;
        line_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SYNC_FIRST;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default settings: one full packet, then a packet left open.
        payload_backlog = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h02};
        drain();

        // Shortening the length below the open count closes the packet on the next byte.
        write_reg(REG_PAYLOAD_LENGTH, 8'd1);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        payload_backlog = '{8'h3C, 8'hC3};
        drain();

        write_reg(REG_SYNC_FIRST, 8'h00);
        write_reg(REG_SYNC_SECOND, 8'hFF);
        write_reg(REG_PAYLOAD_LENGTH, 8'd0);
        payload_backlog = '{8'h00, 8'hFF};
        drain();

        write_reg(REG_SYNC_FIRST, 8'hFF);
        write_reg(REG_SYNC_SECOND, 8'h00);
        write_reg(REG_PAYLOAD_LENGTH, 8'hFF);
        payload_backlog = '{8'h11, 8'h22, 8'h44, 8'h88};
        drain();
        write_reg(REG_PAYLOAD_LENGTH, 8'd16);
        write_reg(REG_PAYLOAD_LENGTH, 8'd3);
        payload_backlog = '{8'hEE};
        drain();
        write_reg(REG_UNMAPPED, 8'h00);
        payload_backlog = '{8'h0F, 8'hF0, 8'h5A};
        drain();

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            write_reg(REG_SYNC_FIRST, pick_sync());
            write_reg(REG_SYNC_SECOND, pick_sync());
            write_reg(REG_PAYLOAD_LENGTH, pick_length());
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            phase_items = $urandom_range(12, 30);
            if (phase == 1 || $urandom_range(0, 3) == 0)
            begin
                queue_random(phase_items / 2);
                drain();
                queue_random(phase_items - phase_items / 2);
            end
            else
                queue_random(phase_items);
            drain();
            random_sent += phase_items;
            phase++;
        end

        repeat (8) @(negedge clk);
        if (fail_count == 0 && owed_line.size() == 0)
            $display("sync_seq_xor_packet_framer: match");
        else
            $display("sync_seq_xor_packet_framer: mismatch");
        $finish;
    end

endmodule
